@@ hw/rtl/ilos_pkg.sv @@
// ----------------------------------------------------------------------------
// ILOS guidance package
// Shared payload types, register indexes, datapath commands and helpers for
// the integral line-of-sight heading guidance block.
// ----------------------------------------------------------------------------
package ilos_pkg;

    // Input item: append a waypoint or give a vehicle position.
    typedef struct packed {
        logic               action;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } ilos_in_t;

    // Result item.
    typedef struct packed {
        logic signed [15:0] desired_heading;
        logic signed [31:0] cross_track;
        logic [5:0]         segment_number;
        logic               status;
    } ilos_out_t;

    // Action codes.
    localparam logic ACT_APPEND   = 1'b0;
    localparam logic ACT_POSITION = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd3;

    // Register reset values.
    localparam logic [30:0] LOOKAHEAD_RST = 31'd327680;
    localparam logic [30:0] ACCEPT_RST    = 31'd131072;
    localparam logic [15:0] STEP_RST      = 16'd6554;
    localparam logic [30:0] GAIN_RST      = 31'd6554;

    // Inverse CORDIC gain, 2^-31 scaling.
    localparam logic [31:0] INV_GAIN = 32'h4DBA76D4;

    // CORDIC datapath width and divider dividend length.
    localparam int CORD_W  = 40;
    localparam int DIV_BITS = 80;
    localparam int CNT_W   = 7;

    // Datapath commands.
    typedef enum logic [4:0] {
        OP_NONE, OP_APPEND, OP_START, OP_BASE, OP_LOAD, OP_ROT,
        OP_UHI, OP_ULO, OP_UFIN, OP_GAIN, OP_LOAD2, OP_HEAD,
        OP_SQ1, OP_SQ2, OP_NUM, OP_PLO, OP_PHI, OP_DIVI, OP_DIV,
        OP_INTEG, OP_STATUS
    } ilos_op_t;

    // Unscale source selects.
    localparam logic [1:0] SEL_D = 2'd0;
    localparam logic [1:0] SEL_S = 2'd1;
    localparam logic [1:0] SEL_E = 2'd2;

    typedef struct packed {
        ilos_op_t   op;
        logic [1:0] sel;
        logic [4:0] idx;
    } ilos_cmd_t;

    typedef struct packed {
        logic few_waypoints;
    } ilos_sts_t;

    // Arctangent of 2^-i, 2^31 = pi.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/ilos_ctrl.sv @@
// ----------------------------------------------------------------------------
// ILOS guidance controller
// Sequences the datapath through segment fetch, CORDIC, unscaling, heading,
// serial division and integration, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ilos_ctrl import ilos_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      in_action,
    output logic      m_valid,
    input  logic      m_ready,
    input  ilos_sts_t sts,
    output ilos_cmd_t cmd
);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_BASE  = 20'h00002,
        S_LOAD  = 20'h00004,
        S_ROT1  = 20'h00008,
        S_UHI   = 20'h00010,
        S_ULO   = 20'h00020,
        S_UFIN  = 20'h00040,
        S_GAIN  = 20'h00080,
        S_LOAD2 = 20'h00100,
        S_ROT2  = 20'h00200,
        S_HEAD  = 20'h00400,
        S_SQ1   = 20'h00800,
        S_SQ2   = 20'h01000,
        S_NUM   = 20'h02000,
        S_PLO   = 20'h04000,
        S_PHI   = 20'h08000,
        S_DIVI  = 20'h10000,
        S_DIV   = 20'h20000,
        S_INTEG = 20'h40000,
        S_STAT  = 20'h80000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;
    logic             s_xfer;
    logic             rot_last;
    logic             div_last;

    assign out_free = !m_valid_reg || m_ready;
    assign s_xfer   = s_valid && s_ready;
    assign rot_last = (cnt_reg == CNT_W'(CORDIC_STEPS - 1));
    assign div_last = (cnt_reg == CNT_W'(DIV_BITS - 1));
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and datapath command.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NONE;
        cmd.sel      = cnt_reg[1:0];
        cmd.idx      = cnt_reg[4:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (in_action == ACT_APPEND) begin
                        cmd.op = OP_APPEND;
                    end else if (sts.few_waypoints) begin
                        state_next = S_STAT;
                    end else begin
                        cmd.op     = OP_START;
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE: begin
                cmd.op     = OP_BASE;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.op     = OP_LOAD;
                cnt_next   = '0;
                state_next = S_ROT1;
            end
            S_ROT1: begin
                cmd.op = OP_ROT;
                if (rot_last) begin
                    cnt_next   = '0;
                    state_next = S_UHI;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UHI: begin
                cmd.op     = OP_UHI;
                state_next = S_ULO;
            end
            S_ULO: begin
                cmd.op     = OP_ULO;
                state_next = S_UFIN;
            end
            S_UFIN: begin
                cmd.op = OP_UFIN;
                if (cnt_reg[1:0] == SEL_E) begin
                    cnt_next   = '0;
                    state_next = S_GAIN;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_UHI;
                end
            end
            S_GAIN: begin
                cmd.op     = OP_GAIN;
                state_next = S_LOAD2;
            end
            S_LOAD2: begin
                cmd.op     = OP_LOAD2;
                cnt_next   = '0;
                state_next = S_ROT2;
            end
            S_ROT2: begin
                cmd.op = OP_ROT;
                if (rot_last) begin
                    cnt_next   = '0;
                    state_next = S_HEAD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_HEAD: begin
                cmd.op     = OP_HEAD;
                state_next = S_SQ1;
            end
            S_SQ1: begin
                cmd.op     = OP_SQ1;
                state_next = S_SQ2;
            end
            S_SQ2: begin
                cmd.op     = OP_SQ2;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.op     = OP_NUM;
                state_next = S_PLO;
            end
            S_PLO: begin
                cmd.op     = OP_PLO;
                state_next = S_PHI;
            end
            S_PHI: begin
                cmd.op     = OP_PHI;
                state_next = S_DIVI;
            end
            S_DIVI: begin
                cmd.op     = OP_DIVI;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = OP_DIV;
                if (div_last) begin
                    cnt_next   = '0;
                    state_next = S_INTEG;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_INTEG: begin
                if (out_free) begin
                    cmd.op       = OP_INTEG;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    cmd.op       = OP_STATUS;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hw/rtl/ilos_dp.sv @@
// ----------------------------------------------------------------------------
// ILOS guidance datapath
// Waypoint memory, configuration registers, shared CORDIC, one shared
// multiplier, serial restoring divider and the result register.
// ----------------------------------------------------------------------------
module ilos_dp import ilos_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  ilos_in_t              in_data,
    input  ilos_cmd_t             cmd,
    output ilos_sts_t             sts,
    output ilos_out_t             res_data
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    // Configuration and architectural state.
    logic [30:0]        lookahead_reg, accept_reg, gain_reg;
    logic [15:0]        step_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      seg_reg;
    logic signed [31:0] integ_reg;

    // Waypoint memory.
    logic signed [31:0] mem_x [MAX_WAYPOINTS];
    logic signed [31:0] mem_y [MAX_WAYPOINTS];
    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [AW-1:0]      rd_addr;

    // Working registers.
    logic signed [31:0]       pos_x_reg, pos_y_reg, base_x_reg, base_y_reg;
    logic signed [CORD_W-1:0] cx_reg, cy_reg, cpx_reg, cpy_reg;
    logic [31:0]              cz_reg, alpha_reg;
    logic                     zero_reg;
    logic signed [65:0]       mul_reg, acc_reg;
    logic signed [CORD_W-1:0] d_reg, s_reg;
    logic signed [31:0]       e32_reg, u_reg;
    logic [15:0]              head_reg;
    logic [63:0]              den_reg, rem_reg;
    logic [62:0]              num_reg;
    logic [DIV_BITS-1:0]      div_reg;
    logic [33:0]              quo_reg;
    ilos_out_t                out_reg;

    // Combinational terms.
    logic [30:0]              delta;
    logic [CW:0]              seg_p1;
    logic [AW-1:0]            k_clamp;
    logic signed [CORD_W-1:0] dx, dy, px, py;
    logic                     ld_zero, ld_neg;
    logic signed [CORD_W-1:0] sx, sy, spx, spy;
    logic [31:0]              atan_i;
    logic signed [CORD_W-1:0] src;
    logic [CORD_W-1:0]        mag;
    logic signed [65:0]       uns_sum;
    logic signed [CORD_W-1:0] uns_mag, uns_val;
    logic signed [32:0]       mul_a, mul_b;
    logic [31:0]              e_abs;
    logic signed [31:0]       u_new;
    logic [31:0]              psi, psi_rnd;
    logic signed [CORD_W:0]   remain;
    logic [64:0]              r_sh;
    logic                     r_ge;
    logic [34:0]              q_sh;
    logic signed [65:0]       integ_sum;
    logic [31:0]              seg_ext;

    assign delta   = (lookahead_reg == '0) ? 31'd1 : lookahead_reg;
    assign seg_ext = 32'(seg_reg);
    assign sts.few_waypoints = (count_reg < CW'(2));
    assign res_data = out_reg;

    // Segment clamp so the segment never passes the last waypoint pair.
    assign seg_p1  = (CW + 1)'(seg_reg) + 1'b1;
    assign k_clamp = (seg_p1 >= (CW + 1)'(count_reg)) ? AW'(count_reg - CW'(2)) : seg_reg;

    // Memory read address.
    always_comb begin
        unique case (cmd.op)
            OP_START: rd_addr = k_clamp;
            OP_BASE:  rd_addr = seg_reg + 1'b1;
            default:  rd_addr = seg_reg;
        endcase
    end

    // Segment vector and vehicle offset.
    assign dx = CORD_W'(rd_x_reg) - CORD_W'(base_x_reg);
    assign dy = CORD_W'(rd_y_reg) - CORD_W'(base_y_reg);
    assign px = CORD_W'(pos_x_reg) - CORD_W'(base_x_reg);
    assign py = CORD_W'(pos_y_reg) - CORD_W'(base_y_reg);
    assign ld_zero = (dx == '0) && (dy == '0);
    assign ld_neg  = dx < 0;

    // One CORDIC vectoring iteration.
    assign sx     = cx_reg >>> cmd.idx;
    assign sy     = cy_reg >>> cmd.idx;
    assign spx    = cpx_reg >>> cmd.idx;
    assign spy    = cpy_reg >>> cmd.idx;
    assign atan_i = atan_entry(cmd.idx);

    // Gain correction of one CORDIC output: magnitude times 1/K, truncated.
    always_comb begin
        unique case (cmd.sel)
            SEL_D:   src = cx_reg;
            SEL_S:   src = cpx_reg;
            default: src = cpy_reg;
        endcase
    end
    assign mag     = (src < 0) ? CORD_W'(-src) : CORD_W'(src);
    assign uns_sum = (acc_reg + (mul_reg >>> 16)) >>> 15;
    assign uns_mag = uns_sum[CORD_W-1:0];
    assign uns_val = zero_reg ? src : ((src < 0) ? -uns_mag : uns_mag);

    assign e_abs = (e32_reg < 0) ? 32'(-33'(e32_reg)) : 32'(e32_reg);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_UHI: begin
                mul_a = {9'd0, mag[CORD_W-1:16]};
                mul_b = {1'b0, INV_GAIN};
            end
            OP_ULO: begin
                mul_a = {17'd0, mag[15:0]};
                mul_b = {1'b0, INV_GAIN};
            end
            OP_GAIN: begin
                mul_a = {2'b00, gain_reg};
                mul_b = {integ_reg[31], integ_reg};
            end
            OP_SQ1: begin
                mul_a = {2'b00, delta};
                mul_b = {2'b00, delta};
            end
            OP_SQ2: begin
                mul_a = {u_reg[31], u_reg};
                mul_b = {u_reg[31], u_reg};
            end
            OP_NUM: begin
                mul_a = {2'b00, delta};
                mul_b = {1'b0, e_abs};
            end
            OP_PLO: begin
                // The numerator product is still in the multiplier register here.
                mul_a = {1'b0, mul_reg[31:0]};
                mul_b = {17'd0, step_reg};
            end
            OP_PHI: begin
                mul_a = {2'b00, num_reg[62:32]};
                mul_b = {17'd0, step_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Proportional plus integral term, saturated.
    assign u_new = sat32(66'(e32_reg) + (mul_reg >>> 16));

    // Heading with round to 16 bits, and the switching distance.
    assign psi     = alpha_reg - cz_reg;
    assign psi_rnd = psi + 32'h00008000;
    assign remain  = (CORD_W + 1)'(d_reg) - (CORD_W + 1)'(s_reg);

    // One restoring division step with the quotient capped at 2^33.
    assign r_sh = {rem_reg, div_reg[DIV_BITS-1]};
    assign r_ge = r_sh >= {1'b0, den_reg};
    assign q_sh = {quo_reg, r_ge};

    // Integral update.
    assign integ_sum = (e32_reg < 0) ? (66'(integ_reg) - 66'(signed'({1'b0, quo_reg})))
                                     : (66'(integ_reg) + 66'(signed'({1'b0, quo_reg})));

    // Configuration and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookahead_reg <= LOOKAHEAD_RST;
            accept_reg    <= ACCEPT_RST;
            step_reg      <= STEP_RST;
            gain_reg      <= GAIN_RST;
            count_reg     <= '0;
            seg_reg       <= '0;
            integ_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_LOOKAHEAD: lookahead_reg <= cfg_wr_data;
                    REG_ACCEPT:    accept_reg    <= cfg_wr_data;
                    REG_STEP:      step_reg      <= cfg_wr_data[15:0];
                    REG_GAIN:      gain_reg      <= cfg_wr_data;
                    default:       ;
                endcase
            end
            if (cmd.op == OP_APPEND && count_reg < CW'(MAX_WAYPOINTS)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.op == OP_START) begin
                seg_reg <= k_clamp;
            end
            // The remaining distance is signed, so a vehicle past the end also switches.
            if (cmd.op == OP_HEAD && remain < $signed((CORD_W + 1)'(accept_reg))
                && (CW + 1)'(seg_reg) + 2'd2 < (CW + 1)'(count_reg)) begin
                seg_reg <= seg_reg + 1'b1;
            end
            if (cmd.op == OP_INTEG) begin
                integ_reg <= sat32(integ_sum);
            end
        end
    end

    // Waypoint memory write and registered read.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_APPEND && count_reg < CW'(MAX_WAYPOINTS)) begin
            mem_x[count_reg[AW-1:0]] <= in_data.coord_x;
            mem_y[count_reg[AW-1:0]] <= in_data.coord_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // Payload datapath.
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        unique case (cmd.op)
            OP_START: begin
                pos_x_reg <= in_data.coord_x;
                pos_y_reg <= in_data.coord_y;
            end
            OP_BASE: begin
                base_x_reg <= rd_x_reg;
                base_y_reg <= rd_y_reg;
            end
            OP_LOAD: begin
                zero_reg <= ld_zero;
                cx_reg   <= ld_neg ? -dx : dx;
                cy_reg   <= ld_neg ? -dy : dy;
                cpx_reg  <= ld_neg ? -px : px;
                cpy_reg  <= ld_neg ? -py : py;
                cz_reg   <= ld_neg ? 32'h80000000 : 32'h0;
            end
            OP_ROT: begin
                if (!zero_reg) begin
                    if (cy_reg >= 0) begin
                        cx_reg  <= cx_reg + sy;
                        cy_reg  <= cy_reg - sx;
                        cpx_reg <= cpx_reg + spy;
                        cpy_reg <= cpy_reg - spx;
                        cz_reg  <= cz_reg + atan_i;
                    end else begin
                        cx_reg  <= cx_reg - sy;
                        cy_reg  <= cy_reg + sx;
                        cpx_reg <= cpx_reg - spy;
                        cpy_reg <= cpy_reg + spx;
                        cz_reg  <= cz_reg - atan_i;
                    end
                end
            end
            OP_ULO: begin
                acc_reg <= mul_reg;
            end
            OP_UFIN: begin
                unique case (cmd.sel)
                    SEL_D:   d_reg   <= uns_val;
                    SEL_S:   s_reg   <= uns_val;
                    default: e32_reg <= sat32(66'(uns_val));
                endcase
            end
            OP_LOAD2: begin
                u_reg     <= u_new;
                alpha_reg <= cz_reg;
                zero_reg  <= 1'b0;
                cx_reg    <= CORD_W'({1'b0, delta});
                cy_reg    <= CORD_W'(u_new);
                cpx_reg   <= '0;
                cpy_reg   <= '0;
                cz_reg    <= '0;
            end
            OP_HEAD: begin
                head_reg <= psi_rnd[31:16];
            end
            OP_SQ2: begin
                acc_reg <= mul_reg;
            end
            OP_NUM: begin
                den_reg <= 64'(acc_reg + mul_reg);
            end
            OP_PLO: begin
                num_reg <= mul_reg[62:0];
            end
            OP_PHI: begin
                acc_reg <= mul_reg;
            end
            OP_DIVI: begin
                div_reg <= (DIV_BITS'(mul_reg) << 32) + DIV_BITS'(acc_reg);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIV: begin
                div_reg <= div_reg << 1;
                rem_reg <= r_ge ? 64'(r_sh - {1'b0, den_reg}) : r_sh[63:0];
                quo_reg <= (q_sh > 35'h200000000) ? 34'h200000000 : q_sh[33:0];
            end
            OP_INTEG: begin
                out_reg.desired_heading <= head_reg;
                out_reg.cross_track     <= e32_reg;
                out_reg.segment_number  <= seg_ext[5:0];
                out_reg.status          <= 1'b0;
            end
            OP_STATUS: begin
                out_reg.desired_heading <= '0;
                out_reg.cross_track     <= '0;
                out_reg.segment_number  <= seg_ext[5:0];
                out_reg.status          <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/ilos_heading_guidance_top.sv @@
// ----------------------------------------------------------------------------
// ILOS heading guidance top level
// Integral line-of-sight path-following guidance over a waypoint table.
// ----------------------------------------------------------------------------
// A waypoint item is stored and gives no result. A position item with fewer
// than two waypoints goes to the status state, which writes its status result
// to the output register once that register is free.
// Otherwise one shared CORDIC runs twice for the path and line-of-sight
// angles, one shared multiplier serves gain correction and the integrator
// terms, and an 80-step restoring divider forms the integral increment. The
// next item is taken once the current one has handed its result to the output
// register, so a result may wait there while new waypoints are loaded.
module ilos_heading_guidance_top import ilos_pkg::*; #(
    parameter int MAX_WAYPOINTS = 64,
    parameter int CORDIC_STEPS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ilos_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ilos_out_t             m_data
);

    ilos_cmd_t cmd;
    ilos_sts_t sts;

    // Sequencer.
    ilos_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_action (s_data.action),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    ilos_dp #(
        .MAX_WAYPOINTS(MAX_WAYPOINTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .res_data    (m_data)
    );

    // A status result never carries a heading or cross-track value.
    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.desired_heading == 0 && m_data.cross_track == 0)
        else $error("status result carries nonzero payload");

    // A position transfer occupies the block for the following cycle.
    a_pos_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.action |=> !s_ready)
        else $error("input accepted while a position is in progress");

    // A waypoint transfer never creates a result.
    a_append_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.action && !m_valid |=> !m_valid)
        else $error("waypoint transfer produced a result");

endmodule
